>>> rtl/core/smsr_pkg.sv
// Package for the concatenated message reassembler core.
// Holds table sizes, derived widths, record kinds and the result record type.
// No dependencies.
package smsr_pkg;

   localparam int SLOT_COUNT = 4;
   localparam int MAX_PARTS  = 8;

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SCAN_W = $clog2(SLOT_COUNT + 1);
   localparam int PIDX_W = $clog2(MAX_PARTS);
   localparam int CNT_W  = $clog2(MAX_PARTS + 1);
   localparam int ADDR_W = $clog2(SLOT_COUNT * MAX_PARTS);

   // Record kinds
   localparam logic [2:0] KIND_RECEIVED = 3'd0;
   localparam logic [2:0] KIND_INVALID  = 3'd1;
   localparam logic [2:0] KIND_EVICTED  = 3'd2;
   localparam logic [2:0] KIND_TIMEOUT  = 3'd3;
   localparam logic [2:0] KIND_PIECE    = 3'd4;
   localparam logic [2:0] KIND_GAP      = 3'd5;
   localparam logic [2:0] KIND_SINGLE   = 3'd6;

   // Operations
   localparam logic OP_PART  = 1'b0;
   localparam logic OP_SWEEP = 1'b1;

   // Configuration register indexes
   localparam logic CSR_TIMEOUT = 1'b0;
   localparam logic CSR_NOTICES = 1'b1;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] ref_num;
      logic [7:0]  part;
      logic [3:0]  received;
      logic [7:0]  total;
      logic [31:0] sender;
      logic [31:0] stamp;
      logic [15:0] handle;
   } rec_type;

endpackage

>>> rtl/core/sms_concat_reassembler_core.sv
// Reassembler core: slot table, part handle memory and record sequencer.
// Depends on smsr_pkg.
//
// Collects parts of concatenated messages in SLOT_COUNT slots and emits each finished,
// evicted or timed-out message as a run of piece/gap records, rsp_tlast on the final
// record of each input. One input is in work at a time: req_tready is high only while
// the sequencer idles. A single or invalid message gives a single record (an invalid one
// first gives an invalid notice if notices are on); a new part gives a received notice
// unless it is a duplicate or notices are off. Completing a message emits its pieces and
// gaps (the handle memory read is registered); an eviction scans the slots for the oldest
// and gives a notice, with notices on, before its pieces and gaps. A sweep checks every slot
// and gives a timeout notice, with notices on, and the pieces and gaps of each timed-out slot.
// Output backpressure can stall any of these. Up to one finished record waits in the output
// register while the next input is taken.
module sms_concat_reassembler_core
   import smsr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // now_time[47:0], ref_number[63:48], part_number[71:64], total_parts[79:72],
   // sender_id[111:80], timestamp_tag[143:112], part_handle[159:144]
   input  logic [159:0] req_tdata,
   // op[0]
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_ref[15:0], out_part[23:16], out_received[27:24], out_total[35:28],
   // out_sender[67:36], out_timestamp[99:68], out_handle[115:100], zero pad[119:116]
   output logic [119:0] rsp_tdata,
   // record_kind[2:0]
   output logic [2:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [47:0]  csr_data
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DECODE = 4'd1;
   localparam logic [3:0] ST_SINGLE = 4'd2;
   localparam logic [3:0] ST_MATCH  = 4'd3;
   localparam logic [3:0] ST_EVSCAN = 4'd4;
   localparam logic [3:0] ST_EVNOTE = 4'd5;
   localparam logic [3:0] ST_PRD    = 4'd6;
   localparam logic [3:0] ST_PEM    = 4'd7;
   localparam logic [3:0] ST_APPLY  = 4'd8;
   localparam logic [3:0] ST_NOTE0  = 4'd9;
   localparam logic [3:0] ST_CHECK  = 4'd10;
   localparam logic [3:0] ST_SWEEP  = 4'd11;
   localparam logic [3:0] ST_SWNOTE = 4'd12;
   localparam logic [3:0] ST_DONE   = 4'd13;

   localparam logic [1:0] RET_EVICT    = 2'd0;
   localparam logic [1:0] RET_COMPLETE = 2'd1;
   localparam logic [1:0] RET_SWEEP    = 2'd2;

   // Control and configuration
   logic [3:0]        state_ff, state_in;
   logic [1:0]        ret_ff, ret_in;
   logic [SLOT_W-1:0] s_ff, s_in;
   logic [SCAN_W-1:0] sc_ff, sc_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [47:0]       timeout_ff;
   logic              notices_ff;

   // Latched input item
   logic        op_ff;
   logic [47:0] now_ff;
   logic [15:0] ref_ff;
   logic [7:0]  part_ff, total_ff;
   logic [31:0] sender_ff, stamp_ff;
   logic [15:0] handle_ff;

   // Slot table
   logic              busy_ff     [SLOT_COUNT];
   logic              busy_in     [SLOT_COUNT];
   logic [15:0]       sref_ff     [SLOT_COUNT];
   logic [15:0]       sref_in     [SLOT_COUNT];
   logic [CNT_W-1:0]  stotal_ff   [SLOT_COUNT];
   logic [CNT_W-1:0]  stotal_in   [SLOT_COUNT];
   logic [CNT_W-1:0]  srecv_ff    [SLOT_COUNT];
   logic [CNT_W-1:0]  srecv_in    [SLOT_COUNT];
   logic [31:0]       ssender_ff  [SLOT_COUNT];
   logic [31:0]       ssender_in  [SLOT_COUNT];
   logic [31:0]       sstamp_ff   [SLOT_COUNT];
   logic [31:0]       sstamp_in   [SLOT_COUNT];
   logic              sstset_ff   [SLOT_COUNT];
   logic              sstset_in   [SLOT_COUNT];
   logic [47:0]       slast_ff    [SLOT_COUNT];
   logic [47:0]       slast_in    [SLOT_COUNT];
   logic [SLOT_COUNT*MAX_PARTS-1:0] present_ff, present_in;

   // Part handle memory
   logic [15:0]       handle_mem [SLOT_COUNT*MAX_PARTS];
   logic [15:0]       mem_rdata_ff;
   logic [ADDR_W-1:0] mem_raddr, mem_waddr;
   logic              mem_we;

   // Output staging: hold_ff keeps the newest record until it is known whether it ends the run
   rec_type hold_ff, hold_in, rsp_rec_ff, rsp_rec_in, push_rec;
   logic    hold_v_ff, hold_v_in, rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic    push_en, can_push, out_free;

   logic [SLOT_COUNT-1:0] stale, match, avail;
   logic [SLOT_W-1:0]     match_idx, avail_idx;
   logic [ADDR_W-1:0]     part_addr;
   logic [PIDX_W-1:0]     part_idx;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_rec_ff.kind;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'd0, rsp_rec_ff.handle, rsp_rec_ff.stamp, rsp_rec_ff.sender,
                        rsp_rec_ff.total, rsp_rec_ff.received, rsp_rec_ff.part,
                        rsp_rec_ff.ref_num};

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign can_push = !hold_v_ff || out_free;

   // Per-slot age, match and availability
   always_comb begin
      match_idx = '0;
      avail_idx = '0;
      for (int j = SLOT_COUNT - 1; j >= 0; j--) begin
         stale[j] = (now_ff - slast_ff[j]) > timeout_ff;
         match[j] = busy_ff[j] && (sref_ff[j] == ref_ff) && (ssender_ff[j] == sender_ff)
                    && (8'(stotal_ff[j]) == total_ff);
         avail[j] = !busy_ff[j] || stale[j];
         if (match[j]) match_idx = SLOT_W'(j);
         if (avail[j]) avail_idx = SLOT_W'(j);
      end
   end

   assign part_idx  = PIDX_W'(part_ff - 8'd1);
   assign part_addr = ADDR_W'(int'(s_ff) * MAX_PARTS + int'(part_idx));

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      s_in       = s_ff;
      sc_in      = sc_ff;
      i_in       = i_ff;
      present_in = present_ff;
      for (int j = 0; j < SLOT_COUNT; j++) begin
         busy_in[j]    = busy_ff[j];
         sref_in[j]    = sref_ff[j];
         stotal_in[j]  = stotal_ff[j];
         srecv_in[j]   = srecv_ff[j];
         ssender_in[j] = ssender_ff[j];
         sstamp_in[j]  = sstamp_ff[j];
         sstset_in[j]  = sstset_ff[j];
         slast_in[j]   = slast_ff[j];
      end
      push_en   = 1'b0;
      push_rec  = '0;
      mem_we    = 1'b0;
      mem_waddr = part_addr;
      mem_raddr = ADDR_W'(int'(s_ff) * MAX_PARTS + int'(i_ff[PIDX_W-1:0]));

      // Slot notice fields, filled per state
      push_rec.ref_num  = sref_ff[s_ff];
      push_rec.received = 4'(srecv_ff[s_ff]);
      push_rec.total    = 8'(stotal_ff[s_ff]);
      push_rec.sender   = ssender_ff[s_ff];
      push_rec.stamp    = sstamp_ff[s_ff];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (op_ff == OP_SWEEP) begin
               sc_in    = '0;
               state_in = ST_SWEEP;
            end else if (total_ff < 8'd2 || part_ff == 8'd0) begin
               state_in = ST_SINGLE;
            end else if (total_ff > 8'(MAX_PARTS) || part_ff > total_ff) begin
               // Out-of-range part: optional notice, then pass through
               if (!notices_ff) begin
                  state_in = ST_SINGLE;
               end else if (can_push) begin
                  push_en           = 1'b1;
                  push_rec.kind     = KIND_INVALID;
                  push_rec.ref_num  = ref_ff;
                  push_rec.part     = part_ff;
                  push_rec.received = 4'd1;
                  push_rec.total    = total_ff;
                  push_rec.sender   = sender_ff;
                  push_rec.stamp    = stamp_ff;
                  push_rec.handle   = '0;
                  state_in          = ST_SINGLE;
               end
            end else begin
               state_in = ST_MATCH;
            end
         end
         ST_SINGLE: begin
            if (can_push) begin
               push_en           = 1'b1;
               push_rec.kind     = KIND_SINGLE;
               push_rec.ref_num  = ref_ff;
               push_rec.part     = '0;
               push_rec.received = '0;
               push_rec.total    = total_ff;
               push_rec.sender   = sender_ff;
               push_rec.stamp    = stamp_ff;
               push_rec.handle   = handle_ff;
               state_in          = ST_DONE;
            end
         end
         ST_MATCH: begin
            if (|match) begin
               s_in     = match_idx;
               state_in = ST_APPLY;
            end else if (|avail) begin
               // Take the slot, dropping any stale content
               s_in                 = avail_idx;
               busy_in[avail_idx]   = 1'b1;
               sref_in[avail_idx]   = ref_ff;
               stotal_in[avail_idx] = CNT_W'(total_ff);
               srecv_in[avail_idx]  = '0;
               ssender_in[avail_idx] = sender_ff;
               sstamp_in[avail_idx] = '0;
               sstset_in[avail_idx] = 1'b0;
               slast_in[avail_idx]  = now_ff;
               for (int p = 0; p < MAX_PARTS; p++)
                  present_in[int'(avail_idx) * MAX_PARTS + p] = 1'b0;
               state_in = ST_APPLY;
            end else begin
               s_in     = '0;
               sc_in    = '0;
               state_in = ST_EVSCAN;
            end
         end
         ST_EVSCAN: begin
            // Find the oldest slot, lowest index on a tie
            if (slast_ff[sc_ff[SLOT_W-1:0]] < slast_ff[s_ff]) s_in = sc_ff[SLOT_W-1:0];
            sc_in = sc_ff + 1'b1;
            if (sc_ff == SCAN_W'(SLOT_COUNT - 1)) state_in = ST_EVNOTE;
         end
         ST_EVNOTE: begin
            if (!notices_ff || can_push) begin
               push_en       = notices_ff;
               push_rec.kind = KIND_EVICTED;
               i_in          = '0;
               ret_in        = RET_EVICT;
               state_in      = ST_PRD;
            end
         end
         ST_PRD: begin
            if (i_ff >= stotal_ff[s_ff] || i_ff >= CNT_W'(MAX_PARTS)) begin
               case (ret_ff)
                  RET_EVICT: begin
                     busy_in[s_ff]    = 1'b1;
                     sref_in[s_ff]    = ref_ff;
                     stotal_in[s_ff]  = CNT_W'(total_ff);
                     srecv_in[s_ff]   = '0;
                     ssender_in[s_ff] = sender_ff;
                     sstamp_in[s_ff]  = '0;
                     sstset_in[s_ff]  = 1'b0;
                     slast_in[s_ff]   = now_ff;
                     state_in         = ST_APPLY;
                  end
                  default: begin
                     busy_in[s_ff]    = 1'b0;
                     sref_in[s_ff]    = '0;
                     stotal_in[s_ff]  = '0;
                     srecv_in[s_ff]   = '0;
                     ssender_in[s_ff] = '0;
                     sstamp_in[s_ff]  = '0;
                     sstset_in[s_ff]  = 1'b0;
                     slast_in[s_ff]   = '0;
                     if (ret_ff == RET_SWEEP) begin
                        sc_in    = sc_ff + 1'b1;
                        state_in = ST_SWEEP;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
               endcase
               for (int p = 0; p < MAX_PARTS; p++)
                  present_in[int'(s_ff) * MAX_PARTS + p] = 1'b0;
            end else begin
               state_in = ST_PEM;
            end
         end
         ST_PEM: begin
            if (can_push) begin
               push_en           = 1'b1;
               push_rec.part     = 8'(i_ff) + 8'd1;
               push_rec.received = '0;
               if (present_ff[mem_raddr]) begin
                  push_rec.kind   = KIND_PIECE;
                  push_rec.handle = mem_rdata_ff;
               end else begin
                  push_rec.kind   = KIND_GAP;
                  push_rec.handle = '0;
               end
               i_in     = i_ff + 1'b1;
               state_in = ST_PRD;
            end
         end
         ST_APPLY: begin
            if (!present_ff[part_addr]) begin
               present_in[part_addr] = 1'b1;
               mem_we                = 1'b1;
               srecv_in[s_ff]        = srecv_ff[s_ff] + 1'b1;
               slast_in[s_ff]        = now_ff;
               if (!sstset_ff[s_ff]) begin
                  sstamp_in[s_ff] = stamp_ff;
                  sstset_in[s_ff] = 1'b1;
               end
               state_in = notices_ff ? ST_NOTE0 : ST_CHECK;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_NOTE0: begin
            if (can_push) begin
               push_en         = 1'b1;
               push_rec.kind   = KIND_RECEIVED;
               push_rec.ref_num = ref_ff;
               push_rec.part   = part_ff;
               push_rec.total  = total_ff;
               push_rec.handle = '0;
               state_in        = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (srecv_ff[s_ff] >= stotal_ff[s_ff]) begin
               i_in     = '0;
               ret_in   = RET_COMPLETE;
               state_in = ST_PRD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SWEEP: begin
            if (sc_ff == SCAN_W'(SLOT_COUNT)) begin
               state_in = ST_DONE;
            end else if (busy_ff[sc_ff[SLOT_W-1:0]] && stale[sc_ff[SLOT_W-1:0]]) begin
               s_in     = sc_ff[SLOT_W-1:0];
               state_in = ST_SWNOTE;
            end else begin
               sc_in = sc_ff + 1'b1;
            end
         end
         ST_SWNOTE: begin
            if (!notices_ff || can_push) begin
               push_en       = notices_ff;
               push_rec.kind = KIND_TIMEOUT;
               i_in          = '0;
               ret_in        = RET_SWEEP;
               state_in      = ST_PRD;
            end
         end
         ST_DONE: begin
            if (!hold_v_ff || out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output staging: a pushed record moves the held one out; the run end flushes with tlast
   always_comb begin
      hold_in      = hold_ff;
      hold_v_in    = hold_v_ff;
      rsp_rec_in   = rsp_rec_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (state_ff == ST_DONE && hold_v_ff && out_free) begin
         rsp_rec_in   = hold_ff;
         rsp_last_in  = 1'b1;
         rsp_valid_in = 1'b1;
         hold_v_in    = 1'b0;
      end else if (push_en) begin
         if (hold_v_ff) begin
            rsp_rec_in   = hold_ff;
            rsp_last_in  = 1'b0;
            rsp_valid_in = 1'b1;
         end
         hold_in   = push_rec;
         hold_v_in = 1'b1;
      end
   end

   // Handle memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) handle_mem[mem_waddr] <= handle_ff;
      mem_rdata_ff <= handle_mem[mem_raddr];
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hold_ff    <= hold_in;
      rsp_rec_ff <= rsp_rec_in;
      if (state_ff == ST_IDLE && req_tvalid) begin
         op_ff     <= req_tuser[0];
         now_ff    <= req_tdata[47:0];
         ref_ff    <= req_tdata[63:48];
         part_ff   <= req_tdata[71:64];
         total_ff  <= req_tdata[79:72];
         sender_ff <= req_tdata[111:80];
         stamp_ff  <= req_tdata[143:112];
         handle_ff <= req_tdata[159:144];
      end
   end

   // Control, configuration and slot table
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= RET_EVICT;
         s_ff         <= '0;
         sc_ff        <= '0;
         i_ff         <= '0;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         timeout_ff   <= 48'd60000000;
         notices_ff   <= 1'b1;
         present_ff   <= '0;
         for (int j = 0; j < SLOT_COUNT; j++) begin
            busy_ff[j]    <= 1'b0;
            sref_ff[j]    <= '0;
            stotal_ff[j]  <= '0;
            srecv_ff[j]   <= '0;
            ssender_ff[j] <= '0;
            sstamp_ff[j]  <= '0;
            sstset_ff[j]  <= 1'b0;
            slast_ff[j]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         s_ff         <= s_in;
         sc_ff        <= sc_in;
         i_ff         <= i_in;
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         present_ff   <= present_in;
         for (int j = 0; j < SLOT_COUNT; j++) begin
            busy_ff[j]    <= busy_in[j];
            sref_ff[j]    <= sref_in[j];
            stotal_ff[j]  <= stotal_in[j];
            srecv_ff[j]   <= srecv_in[j];
            ssender_ff[j] <= ssender_in[j];
            sstamp_ff[j]  <= sstamp_in[j];
            sstset_ff[j]  <= sstset_in[j];
            slast_ff[j]   <= slast_in[j];
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_TIMEOUT: timeout_ff <= csr_data;
               CSR_NOTICES: notices_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

endmodule
